[hw/rtl/assert_macros.svh]
// concurrent assertion helpers, compiled out for synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every rising edge outside reset
`define ASSERT_AT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("%m: assertion failed");

// condition must never be seen outside reset
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("%m: forbidden condition seen");

`else

`define ASSERT_AT(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

[hw/rtl/mipsde_pkg.sv]
package mipsde_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned RegW   = 5;
  localparam int unsigned InDataW  = 128;
  localparam int unsigned OutDataW = 112;

  // primary opcodes
  localparam logic [5:0] OP_RTYPE = 6'h00;
  localparam logic [5:0] OP_J     = 6'h02;
  localparam logic [5:0] OP_BEQ   = 6'h04;
  localparam logic [5:0] OP_BNE   = 6'h05;
  localparam logic [5:0] OP_BGTZ  = 6'h07;
  localparam logic [5:0] OP_ADDI  = 6'h08;
  localparam logic [5:0] OP_ADDIU = 6'h09;
  localparam logic [5:0] OP_SLTI  = 6'h0a;
  localparam logic [5:0] OP_ORI   = 6'h0d;
  localparam logic [5:0] OP_LUI   = 6'h0f;
  localparam logic [5:0] OP_LW    = 6'h23;
  localparam logic [5:0] OP_SW    = 6'h2b;

  // r-type function codes
  localparam logic [5:0] FN_ADD  = 6'h20;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUB  = 6'h22;
  localparam logic [5:0] FN_SUBU = 6'h23;
  localparam logic [5:0] FN_SLT  = 6'h2a;
  localparam logic [5:0] FN_SLTU = 6'h2b;

  typedef struct packed {
    logic [WordW-1:0] instruction;
    logic [WordW-1:0] pc_plus4;
    logic [WordW-1:0] rs_word;
    logic [WordW-1:0] rt_word;
  } item_t;

  typedef struct packed {
    logic [WordW-1:0] alu_result;
    logic [WordW-1:0] store_data;
    logic [RegW-1:0]  write_reg;
    logic             wb_enable;
    logic             load_to_reg;
    logic             mem_write;
    logic             redirect;
    logic [WordW-1:0] redirect_target;
    logic             unsupported;
  } result_t;

endpackage

[hw/rtl/mips_subset_decode_execute.sv]
// channel | dir | tdata fields, low bit first                          | tlast/tuser
// s_axis  | in  | instruction, pc_plus4, rs_word, rt_word (128 bits)   | none
// m_axis  | out | alu_result, store_data, write_reg, wb_enable,         | none
//         |     | load_to_reg, mem_write, redirect, redirect_target,    |
//         |     | unsupported, 6 zero pad bits (112 bits)               |
//
// one transfer per cycle in and out while m_tready holds; the input register
// and the result register sit around the decode/alu logic
// rst is synchronous, active high, and clears only the two valid flags
// a stalled result holds in the result register while the input register
// still takes a new transfer if it is empty
`include "assert_macros.svh"

module mips_subset_decode_execute (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // instruction[31:0], pc_plus4[63:32], rs_word[95:64], rt_word[127:96]
  input  logic [mipsde_pkg::InDataW-1:0]    s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // alu_result[31:0], store_data[63:32], write_reg[68:64], wb_enable[69],
  // load_to_reg[70], mem_write[71], redirect[72], redirect_target[104:73],
  // unsupported[105], zero[111:106]
  output logic [mipsde_pkg::OutDataW-1:0]   m_tdata
);
  import mipsde_pkg::*;

  // input register stage
  logic    in_valid;
  item_t   in_item;
  logic    in_load;
  logic    res_load;

  // result register stage
  logic    res_valid;
  result_t res;
  result_t res_next;
  logic    res_acts;

  // decode fields
  logic [5:0]       op;
  logic [5:0]       fn;
  logic [15:0]      imm;
  logic [WordW-1:0] simm;
  logic [WordW-1:0] rs;
  logic [WordW-1:0] rt;
  logic [WordW-1:0] sum_imm;
  logic [WordW-1:0] diff;
  logic             bad;

  // each stage moves when its downstream side is empty or draining
  assign res_load = in_valid && (!res_valid || m_tready);
  assign s_tready = !in_valid || res_load;
  assign in_load  = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      in_item <= item_t'({s_tdata[31:0], s_tdata[63:32], s_tdata[95:64], s_tdata[127:96]});
    end
  end

  always_comb begin
    op      = in_item.instruction[31:26];
    fn      = in_item.instruction[5:0];
    imm     = in_item.instruction[15:0];
    simm    = {{16{imm[15]}}, imm};
    rs      = in_item.rs_word;
    rt      = in_item.rt_word;
    sum_imm = rs + simm;
    diff    = rs - rt;
    bad     = 1'b0;

    res_next                 = '0;
    res_next.store_data      = rt;
    res_next.write_reg       = in_item.instruction[20:16];

    case (op)
      OP_RTYPE: begin
        res_next.write_reg = in_item.instruction[15:11];
        res_next.wb_enable = 1'b1;
        case (fn)
          FN_ADD, FN_ADDU: res_next.alu_result = rs + rt;
          FN_SUB, FN_SUBU: res_next.alu_result = diff;
          FN_SLT:  res_next.alu_result = {31'd0, $signed(rs) < $signed(rt)};
          FN_SLTU: res_next.alu_result = {31'd0, rs < rt};
          default: bad = 1'b1;
        endcase
      end
      OP_LW: begin
        res_next.alu_result  = sum_imm;
        res_next.wb_enable   = 1'b1;
        res_next.load_to_reg = 1'b1;
      end
      OP_SW: begin
        res_next.alu_result = sum_imm;
        res_next.mem_write  = 1'b1;
      end
      OP_ADDI, OP_ADDIU: begin
        res_next.alu_result = sum_imm;
        res_next.wb_enable  = 1'b1;
      end
      OP_SLTI: begin
        res_next.alu_result = {31'd0, $signed(rs) < $signed(simm)};
        res_next.wb_enable  = 1'b1;
      end
      OP_ORI: begin
        // ori zero-extends its immediate
        res_next.alu_result = rs | {16'd0, imm};
        res_next.wb_enable  = 1'b1;
      end
      OP_LUI: begin
        res_next.alu_result = {imm, 16'd0};
        res_next.wb_enable  = 1'b1;
      end
      OP_BEQ: begin
        res_next.alu_result = diff;
        res_next.redirect   = (diff == '0);
      end
      OP_BNE: begin
        res_next.alu_result = diff;
        res_next.redirect   = (diff != '0);
      end
      OP_BGTZ: begin
        res_next.alu_result = {31'd0, $signed(rs) > $signed(32'sd0)};
        res_next.redirect   = $signed(rs) > $signed(32'sd0);
      end
      OP_J: begin
        res_next.redirect        = 1'b1;
        res_next.redirect_target = {in_item.pc_plus4[31:28],
                                    in_item.instruction[25:0], 2'b00};
      end
      default: bad = 1'b1;
    endcase

    // taken branch target, relative to pc+4
    if (res_next.redirect && (op != OP_J)) begin
      res_next.redirect_target = in_item.pc_plus4 + {simm[29:0], 2'b00};
    end

    // unknown codes clear everything but the flag
    if (bad) begin
      res_next             = '0;
      res_next.unsupported = 1'b1;
    end

    // bubble: all-zero word gives an all-zero result
    if (in_item.instruction == '0) begin
      res_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (!res_valid || m_tready) begin
      res_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res <= res_next;
    end
  end

  assign m_tvalid = res_valid;
  assign m_tdata  = {6'd0, res.unsupported, res.redirect_target, res.redirect,
                     res.mem_write, res.load_to_reg, res.wb_enable, res.write_reg,
                     res.store_data, res.alu_result};

  // result writes, stores or redirects
  assign res_acts = res.wb_enable || res.mem_write || res.redirect;

  // an unsupported result never writes or redirects
  `ASSERT_NEVER(a_bad_quiet, clk, rst, res_valid && res.unsupported && res_acts)
  // no redirect means a zero target
  `ASSERT_NEVER(a_tgt_zero, clk, rst, res_valid && !res.redirect && (res.redirect_target != '0))
  // a load always writes back and never stores
  `ASSERT_NEVER(a_ld_ctl, clk, rst, res_valid && res.load_to_reg && (!res.wb_enable || res.mem_write))
  // an item leaving the input register shows up as a result next cycle
  `ASSERT_AT(a_advance, clk, rst, res_load |=> res_valid)

endmodule
